// ----- hdl/spl_pkg.sv -----
`timescale 1ns / 1ps

package spl_pkg;

  localparam int SERVO_NUM   = 4;
  localparam int SERVO_IDX_W = (SERVO_NUM > 1) ? $clog2(SERVO_NUM) : 1;

  localparam int FUNC_W    = 2;
  localparam int SIDX_W    = 4;
  localparam int TGT_W     = 18;
  localparam int ANG_W     = 17;
  localparam int PULSE_W   = 15;
  localparam int MV_W      = 12;
  localparam int GAIN_W    = 16;
  localparam int TOL_W     = 16;
  localparam int DUTY_W    = 16;
  localparam int CFG_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam int PERIOD_US   = 20000;
  localparam int DUTY_DEN    = PERIOD_US / 32;
  localparam int DUTY_NUM_SH = 16 - 5;
  localparam int RECIP_W     = 23;
  localparam int RECIP_SH    = 32 - DUTY_NUM_SH;
  localparam logic [RECIP_W-1:0] DUTY_RECIP = RECIP_W'((64'd1 << 32) / 64'(DUTY_DEN));

  localparam int DIV_NUM_W = 32;
  localparam int DIV_DEN_W = 17;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

  localparam logic signed [ANG_W-1:0] ANG_LO_RST  = -17'sd23040;
  localparam logic signed [ANG_W-1:0] ANG_HI_RST  = 17'sd23040;
  localparam logic [PULSE_W-1:0]      PULSE_LO_RST = 15'd1000;
  localparam logic [PULSE_W-1:0]      PULSE_HI_RST = 15'd2000;
  localparam logic [MV_W-1:0]         FB_LO_RST    = 12'd100;
  localparam logic [MV_W-1:0]         FB_HI_RST    = 12'd3100;
  localparam logic [GAIN_W-1:0]       GAIN_RST     = 16'd6554;
  localparam logic [TOL_W-1:0]        TOL_RST      = 16'd384;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET = 2'd0,
    FUNC_FB  = 2'd1,
    FUNC_EN  = 2'd2,
    FUNC_NOP = 2'd3
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE_LOW = 3'd0,
    REG_ANGLE_HIGH = 3'd1,
    REG_PULSE_LOW = 3'd2,
    REG_PULSE_HIGH = 3'd3,
    REG_FB_LOW = 3'd4,
    REG_FB_HIGH = 3'd5,
    REG_GAIN = 3'd6,
    REG_TOL = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_BAD,
    KIND_SET,
    KIND_FB,
    KIND_EN,
    KIND_NOP
  } item_kind_t;

  typedef enum logic {
    DIV_SEL_FB,
    DIV_SEL_DT
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SET_CLAMP,
    ST_FB_MUL,
    ST_FB_DIV,
    ST_FB_WAIT,
    ST_FB_MEAS,
    ST_ERR_MUL,
    ST_CMD_CLAMP,
    ST_DT_MUL,
    ST_DT_DIV,
    ST_DT_WAIT,
    ST_DT_PULSE,
    ST_RC_MUL,
    ST_RC_CORR,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic     latch;
    logic     set_clamp;
    logic     fb_mul;
    logic     div_start;
    div_sel_t div_sel;
    logic     fb_meas;
    logic     err_mul;
    logic     cmd_clamp;
    logic     dt_mul;
    logic     dt_pulse;
    logic     rc_mul;
    logic     rc_corr;
    logic     en_wr;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    item_kind_t kind;
    logic       div_done;
    logic       over_tol;
    logic       out_free;
  } dp_status_t;

  function automatic logic signed [ANG_W-1:0] clamp_angle(
    input logic signed [ANG_W+1:0] a,
    input logic signed [ANG_W-1:0] lo,
    input logic signed [ANG_W-1:0] hi
  );
    logic signed [ANG_W+1:0] t;
    logic signed [ANG_W+1:0] lo_x;
    logic signed [ANG_W+1:0] hi_x;
    lo_x = lo;
    hi_x = hi;
    t = a;
    if (t > hi_x) t = hi_x;
    if (t < lo_x) t = lo_x;
    return t[ANG_W-1:0];
  endfunction

endpackage

// ----- hdl/spl_in_if.sv -----
`timescale 1ns / 1ps

interface spl_in_if;
  import spl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [SIDX_W-1:0]        servo_index;
  logic signed [TGT_W-1:0]  target_value;
  logic                     enable_flag;
  logic [MV_W-1:0]          sample_mv;

  modport source (
    output valid, func, servo_index, target_value, enable_flag, sample_mv,
    input  ready
  );

  modport sink (
    input  valid, func, servo_index, target_value, enable_flag, sample_mv,
    output ready
  );
endinterface

// ----- hdl/spl_out_if.sv -----
`timescale 1ns / 1ps

interface spl_out_if;
  import spl_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [SIDX_W-1:0]        servo_out;
  logic [DUTY_W-1:0]        duty_word;
  logic                     duty_valid;
  logic signed [ANG_W-1:0]  angle_report;
  logic                     status;

  modport source (
    output valid, servo_out, duty_word, duty_valid, angle_report, status,
    input  ready
  );

  modport sink (
    input  valid, servo_out, duty_word, duty_valid, angle_report, status,
    output ready
  );
endinterface

// ----- hdl/spl_div.sv -----
`timescale 1ns / 1ps

module spl_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [spl_pkg::DIV_NUM_W-1:0]  num,
  input  logic [spl_pkg::DIV_DEN_W-1:0]  den,
  output logic [spl_pkg::DIV_NUM_W-1:0]  quot,
  output logic                           rem_nz,
  output logic                           done
);
  import spl_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic [DIV_NUM_W-1:0]  quo_r;
  logic [DIV_DEN_W-1:0]  rem_r;
  logic [DIV_DEN_W-1:0]  den_r;

  logic [DIV_DEN_W:0]    rem_sh;
  logic [DIV_DEN_W+1:0]  diff;
  logic                  ge;
  logic [DIV_DEN_W-1:0]  rem_nxt;
  logic [DIV_NUM_W-1:0]  quo_nxt;

  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_NUM_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, den_r};
    ge      = !diff[DIV_DEN_W+1];
    rem_nxt = ge ? diff[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
    quo_nxt = {quo_r[DIV_NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quot   = quo_r;
  assign rem_nz = |rem_r;
  assign done   = done_r;

endmodule

// ----- hdl/spl_dpath.sv -----
`timescale 1ns / 1ps

module spl_dpath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [spl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [spl_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic [spl_pkg::FUNC_W-1:0]       in_func,
  input  logic [spl_pkg::SIDX_W-1:0]       in_servo_index,
  input  logic signed [spl_pkg::TGT_W-1:0] in_target_value,
  input  logic                             in_enable_flag,
  input  logic [spl_pkg::MV_W-1:0]         in_sample_mv,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spl_pkg::SIDX_W-1:0]       out_servo_out,
  output logic [spl_pkg::DUTY_W-1:0]       out_duty_word,
  output logic                             out_duty_valid,
  output logic signed [spl_pkg::ANG_W-1:0] out_angle_report,
  output logic                             out_status,
  input  spl_pkg::ctrl_cmd_t               cmd,
  output spl_pkg::dp_status_t              status
);
  import spl_pkg::*;

  // configuration
  logic signed [ANG_W-1:0] ang_lo_r;
  logic signed [ANG_W-1:0] ang_hi_r;
  logic [PULSE_W-1:0]      pl_r;
  logic [PULSE_W-1:0]      ph_r;
  logic [MV_W-1:0]         flo_r;
  logic [MV_W-1:0]         fhi_r;
  logic [GAIN_W-1:0]       gain_r;
  logic [TOL_W-1:0]        tol_r;

  // item
  logic [FUNC_W-1:0]       func_r;
  logic [SIDX_W-1:0]       servo_r;
  logic signed [TGT_W-1:0] tval_r;
  logic                    en_r;
  logic [MV_W-1:0]         smp_r;

  // per-servo state
  logic signed [ANG_W-1:0] tgt_r   [SERVO_NUM];
  logic signed [ANG_W-1:0] meas_r  [SERVO_NUM];
  logic                    fb_on_r [SERVO_NUM];

  // working registers
  logic signed [ANG_W-1:0]     angle_r;
  logic signed [33:0]          prod_r;
  logic signed [ANG_W-1:0]     meas_cur_r;
  logic                        over_tol_r;
  logic                        neg_r;
  logic [ANG_W-1:0]            pulse_r;
  logic [ANG_W+RECIP_W-1:0]    rprod_r;
  logic [DUTY_W-1:0]           duty_r;
  logic                        dvalid_r;

  logic                        out_valid_r;
  logic [SIDX_W-1:0]           o_servo_r;
  logic [DUTY_W-1:0]           o_duty_r;
  logic                        o_dvalid_r;
  logic signed [ANG_W-1:0]     o_angle_r;
  logic                        o_status_r;

  logic [SERVO_IDX_W-1:0]      sidx;
  item_kind_t                  kind;
  logic signed [ANG_W-1:0]     tgt_cur;

  logic signed [ANG_W:0]       span_a;
  logic                        ang_gt;
  logic [MV_W-1:0]             v_lo;
  logic [MV_W-1:0]             v_cl;
  logic signed [MV_W:0]        vd;
  logic signed [MV_W:0]        fspan;
  logic [MV_W:0]               fspan_mag;
  logic signed [30:0]          fb_prod;
  logic signed [ANG_W:0]       a_off;
  logic signed [PULSE_W:0]     pdiff;
  logic signed [33:0]          dt_prod;
  logic signed [ANG_W:0]       err;
  logic [ANG_W:0]              err_mag;
  logic signed [34:0]          gain_prod;

  logic [33:0]                 prod_mag;
  logic [DIV_DEN_W-1:0]        div_den;
  logic                        div_neg;
  logic [DIV_NUM_W-1:0]        quot;
  logic                        rem_nz;
  logic                        div_done;

  logic signed [ANG_W+1:0]     qm_fb;
  logic signed [ANG_W+1:0]     qs_fb;
  logic signed [ANG_W+1:0]     hi_x;
  logic signed [ANG_W+1:0]     m_full;
  logic signed [ANG_W-1:0]     m_new;
  logic signed [ANG_W:0]       qm_dt;
  logic signed [ANG_W:0]       qf_dt;
  logic signed [ANG_W:0]       pulse_full;
  logic [ANG_W-1:0]            pulse_new;
  logic signed [ANG_W+1:0]     meas_x;
  logic signed [ANG_W+1:0]     corr_x;
  logic signed [ANG_W+1:0]     cmd_ang;
  logic signed [ANG_W+1:0]     tval_x;
  logic [18:0]                 qe;
  logic [28:0]                 rc_rem;
  logic [18:0]                 dsum;

  assign sidx    = servo_r[SERVO_IDX_W-1:0];
  assign tgt_cur = tgt_r[sidx];

  always_comb begin
    if ({1'b0, servo_r} >= (SIDX_W + 1)'(SERVO_NUM)) begin
      kind = KIND_BAD;
    end else begin
      unique case (func_t'(func_r))
        FUNC_SET: kind = KIND_SET;
        FUNC_FB:  kind = fb_on_r[sidx] ? KIND_FB : KIND_NOP;
        FUNC_EN:  kind = KIND_EN;
        FUNC_NOP: kind = KIND_NOP;
        default:  kind = KIND_NOP;
      endcase
    end
  end

  // arithmetic
  always_comb begin
    span_a    = {ang_hi_r[ANG_W-1], ang_hi_r} - {ang_lo_r[ANG_W-1], ang_lo_r};
    ang_gt    = ang_hi_r > ang_lo_r;
    v_lo      = (smp_r < flo_r) ? flo_r : smp_r;
    v_cl      = (v_lo > fhi_r) ? fhi_r : v_lo;
    vd        = {1'b0, v_cl} - {1'b0, flo_r};
    fspan     = {1'b0, fhi_r} - {1'b0, flo_r};
    fspan_mag = fspan[MV_W] ? -fspan : fspan;
    fb_prod   = vd * span_a;
    a_off     = {angle_r[ANG_W-1], angle_r} - {ang_lo_r[ANG_W-1], ang_lo_r};
    pdiff     = {1'b0, ph_r} - {1'b0, pl_r};
    dt_prod   = a_off * pdiff;
    err       = {tgt_cur[ANG_W-1], tgt_cur} - {meas_cur_r[ANG_W-1], meas_cur_r};
    err_mag   = err[ANG_W] ? -err : err;
    gain_prod = $signed({1'b0, gain_r}) * err;

    prod_mag  = prod_r[33] ? -prod_r : prod_r;
    if (cmd.div_sel == DIV_SEL_FB) begin
      div_den = DIV_DEN_W'(fspan_mag);
      div_neg = prod_r[33] ^ fspan[MV_W];
    end else begin
      div_den = span_a[DIV_DEN_W-1:0];
      div_neg = prod_r[33];
    end

    qm_fb  = {2'b00, quot[ANG_W-1:0]};
    qs_fb  = neg_r ? -qm_fb : qm_fb;
    hi_x   = ang_hi_r;
    m_full = hi_x - qs_fb;
    m_new  = (fspan == '0) ? ang_hi_r : m_full[ANG_W-1:0];

    qm_dt      = {1'b0, quot[ANG_W-1:0]};
    qf_dt      = neg_r ? -(qm_dt + (ANG_W + 1)'(rem_nz)) : qm_dt;
    pulse_full = ang_gt ? ({3'b000, pl_r} + qf_dt) : {3'b000, pl_r};
    pulse_new  = pulse_full[ANG_W] ? '0 : pulse_full[ANG_W-1:0];

    meas_x  = meas_cur_r;
    corr_x  = $signed(prod_r[33:16]);
    cmd_ang = meas_x + corr_x;
    tval_x  = tval_r;

    qe     = rprod_r[ANG_W+RECIP_W-1:RECIP_SH];
    rc_rem = (29'(pulse_r) << DUTY_NUM_SH) - 29'(qe) * 29'(DUTY_DEN);
    dsum   = qe + 19'(rc_rem >= 29'(DUTY_DEN));
  end

  spl_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.div_start),
    .num    (prod_mag[DIV_NUM_W-1:0]),
    .den    (div_den),
    .quot   (quot),
    .rem_nz (rem_nz),
    .done   (div_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_lo_r <= ANG_LO_RST;
      ang_hi_r <= ANG_HI_RST;
      pl_r     <= PULSE_LO_RST;
      ph_r     <= PULSE_HI_RST;
      flo_r    <= FB_LO_RST;
      fhi_r    <= FB_HI_RST;
      gain_r   <= GAIN_RST;
      tol_r    <= TOL_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_ANGLE_LOW:  ang_lo_r <= cfg_wdata[ANG_W-1:0];
        REG_ANGLE_HIGH: ang_hi_r <= cfg_wdata[ANG_W-1:0];
        REG_PULSE_LOW:  pl_r     <= cfg_wdata[PULSE_W-1:0];
        REG_PULSE_HIGH: ph_r     <= cfg_wdata[PULSE_W-1:0];
        REG_FB_LOW:     flo_r    <= cfg_wdata[MV_W-1:0];
        REG_FB_HIGH:    fhi_r    <= cfg_wdata[MV_W-1:0];
        REG_GAIN:       gain_r   <= cfg_wdata[GAIN_W-1:0];
        REG_TOL:        tol_r    <= cfg_wdata[TOL_W-1:0];
        default:        tol_r    <= tol_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SERVO_NUM; i++) begin
        tgt_r[i]   <= '0;
        meas_r[i]  <= '0;
        fb_on_r[i] <= 1'b0;
      end
    end else begin
      if (cmd.set_clamp) tgt_r[sidx] <= clamp_angle(tval_x, ang_lo_r, ang_hi_r);
      if (cmd.fb_meas)   meas_r[sidx] <= m_new;
      if (cmd.en_wr)     fb_on_r[sidx] <= en_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r  <= in_func;
      servo_r <= in_servo_index;
      tval_r  <= in_target_value;
      en_r    <= in_enable_flag;
      smp_r   <= in_sample_mv;
    end
    if (cmd.set_clamp) angle_r <= clamp_angle(tval_x, ang_lo_r, ang_hi_r);
    if (cmd.cmd_clamp) angle_r <= clamp_angle(cmd_ang, ang_lo_r, ang_hi_r);
    if (cmd.fb_mul) begin
      prod_r <= 34'(fb_prod);
    end else if (cmd.err_mul) begin
      prod_r <= gain_prod[33:0];
    end else if (cmd.dt_mul) begin
      prod_r <= dt_prod;
    end
    if (cmd.div_start) neg_r <= div_neg;
    if (cmd.fb_meas)   meas_cur_r <= m_new;
    if (cmd.err_mul)   over_tol_r <= err_mag > (ANG_W + 1)'(tol_r);
    if (cmd.dt_pulse)  pulse_r <= pulse_new;
    if (cmd.rc_mul)    rprod_r <= (ANG_W + RECIP_W)'(pulse_r) * (ANG_W + RECIP_W)'(DUTY_RECIP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r <= 1'b0;
      duty_r   <= '0;
    end else if (cmd.latch) begin
      dvalid_r <= 1'b0;
      duty_r   <= '0;
    end else if (cmd.rc_corr) begin
      dvalid_r <= 1'b1;
      duty_r   <= (|dsum[18:DUTY_W]) ? '1 : dsum[DUTY_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      o_servo_r <= servo_r;
      if (kind == KIND_BAD) begin
        o_duty_r   <= '0;
        o_dvalid_r <= 1'b0;
        o_angle_r  <= '0;
        o_status_r <= 1'b1;
      end else begin
        o_duty_r   <= duty_r;
        o_dvalid_r <= dvalid_r;
        o_angle_r  <= fb_on_r[sidx] ? meas_r[sidx] : tgt_cur;
        o_status_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_servo_out    = o_servo_r;
  assign out_duty_word    = o_duty_r;
  assign out_duty_valid   = o_dvalid_r;
  assign out_angle_report = o_angle_r;
  assign out_status       = o_status_r;

  assign status.kind     = kind;
  assign status.div_done = div_done;
  assign status.over_tol = over_tol_r;
  assign status.out_free = !out_valid_r || out_ready;

endmodule

// ----- hdl/spl_ctrl.sv -----
`timescale 1ns / 1ps

module spl_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  spl_pkg::dp_status_t  status,
  output spl_pkg::ctrl_cmd_t   cmd
);
  import spl_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    cmd.div_sel = DIV_SEL_DT;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (status.kind)
          KIND_SET: state_nxt = ST_SET_CLAMP;
          KIND_FB:  state_nxt = ST_FB_MUL;
          KIND_EN: begin
            cmd.en_wr = 1'b1;
            state_nxt = ST_EMIT;
          end
          KIND_BAD, KIND_NOP: state_nxt = ST_EMIT;
          default: state_nxt = ST_EMIT;
        endcase
      end
      ST_SET_CLAMP: begin
        cmd.set_clamp = 1'b1;
        state_nxt     = ST_DT_MUL;
      end
      ST_FB_MUL: begin
        cmd.fb_mul = 1'b1;
        state_nxt  = ST_FB_DIV;
      end
      ST_FB_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_SEL_FB;
        state_nxt     = ST_FB_WAIT;
      end
      ST_FB_WAIT: begin
        cmd.div_sel = DIV_SEL_FB;
        if (status.div_done) state_nxt = ST_FB_MEAS;
      end
      ST_FB_MEAS: begin
        cmd.fb_meas = 1'b1;
        state_nxt   = ST_ERR_MUL;
      end
      ST_ERR_MUL: begin
        cmd.err_mul = 1'b1;
        state_nxt   = ST_CMD_CLAMP;
      end
      ST_CMD_CLAMP: begin
        if (status.over_tol) begin
          cmd.cmd_clamp = 1'b1;
          state_nxt     = ST_DT_MUL;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_DT_MUL: begin
        cmd.dt_mul = 1'b1;
        state_nxt  = ST_DT_DIV;
      end
      ST_DT_DIV: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DT_WAIT;
      end
      ST_DT_WAIT: begin
        if (status.div_done) state_nxt = ST_DT_PULSE;
      end
      ST_DT_PULSE: begin
        cmd.dt_pulse = 1'b1;
        state_nxt    = ST_RC_MUL;
      end
      ST_RC_MUL: begin
        cmd.rc_mul = 1'b1;
        state_nxt  = ST_RC_CORR;
      end
      ST_RC_CORR: begin
        cmd.rc_corr = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/servo_position_loop_core.sv -----
`timescale 1ns / 1ps

// Position loop for SERVO_NUM servos, one item at a time, one result per item. An item
// with no arithmetic (enable, unused code, bad index, feedback while disabled) gives its
// result without a division; a set item waits for one division; a feedback item waits for
// one inside the deadband and for two with a correction. The wait is set by the shared
// radix-2 divider, used once for the pulse mapping and once more for the sample-to-angle
// mapping. The next item is taken as soon as the result sits in the output register, even
// while that register waits for the sink.

module servo_position_loop_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [spl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [spl_pkg::CFG_W-1:0]       cfg_wdata,
  spl_in_if.sink                          in_ch,
  spl_out_if.source                       out_ch
);
  import spl_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t dp_st;

  spl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .status   (dp_st),
    .cmd      (cmd)
  );

  spl_dpath u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_func          (in_ch.func),
    .in_servo_index   (in_ch.servo_index),
    .in_target_value  (in_ch.target_value),
    .in_enable_flag   (in_ch.enable_flag),
    .in_sample_mv     (in_ch.sample_mv),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_servo_out    (out_ch.servo_out),
    .out_duty_word    (out_ch.duty_word),
    .out_duty_valid   (out_ch.duty_valid),
    .out_angle_report (out_ch.angle_report),
    .out_status       (out_ch.status),
    .cmd              (cmd),
    .status           (dp_st)
  );

  a_busy_after_transfer : assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready stayed high after a transfer");

  a_div_start_clears_done : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> !dp_st.div_done)
    else $error("divider reported done right after a start");

  a_out_from_emit : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(cmd.emit))
    else $error("result appeared without an emit command");

endmodule
